// ----- rtl/best_rational_approximation_defines.svh -----
// Assertion macros for the best rational approximation block.
`ifndef BEST_RATIONAL_APPROXIMATION_DEFINES_SVH
`define BEST_RATIONAL_APPROXIMATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BRA_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("best_rational_approximation: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define BRA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("best_rational_approximation: next-cycle check failed");

`endif

// ----- rtl/bra_pkg.sv -----
// Shared constants and controller/datapath interface types.
package bra_pkg;

    localparam int FRAC_BITS_DEF  = 32;
    localparam int INT_BITS_DEF   = 16;
    localparam int DENOM_BITS_DEF = 16;
    localparam int NUM_W          = 32;
    localparam int LIMIT_RESET    = 200;

    typedef struct packed {
        logic load;       // start a new request from the input port
        logic advance;    // replace one Farey bound by the mediant
        logic pick_hit;   // exact hit on the mediant: select the result
        logic pick_end;   // search over: select the in-range bound
        logic mul;        // integer part times denominator
        logic load_out;   // fill the output register
    } t_cmd;

    typedef struct packed {
        logic in_range;   // both bound denominators within the limit
        logic hit;        // mediant equals the value exactly
    } t_status;

endpackage

// ----- rtl/bra_datapath.sv -----
// Datapath: limit register, Farey bounds with running error terms, result assembly.
module bra_datapath #(
    parameter int FRAC_BITS  = bra_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS   = bra_pkg::INT_BITS_DEF,
    parameter int DENOM_BITS = bra_pkg::DENOM_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [DENOM_BITS-1:0]        i_cfg_wr_data,
    input  logic [INT_BITS+FRAC_BITS-1:0] i_value_fixed,
    input  bra_pkg::t_cmd                i_cmd,
    output bra_pkg::t_status             o_status,
    output logic [bra_pkg::NUM_W-1:0]    o_numerator,
    output logic [DENOM_BITS-1:0]        o_denominator
);
    import bra_pkg::*;

    localparam int BW = DENOM_BITS + 1;
    localparam int EW = FRAC_BITS + DENOM_BITS + 3;
    localparam int PW = INT_BITS + DENOM_BITS;
    localparam int SW = NUM_W + 1;
    localparam logic [EW-1:0] ONE_F =
        {{(EW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    logic [DENOM_BITS-1:0] r_max_den;
    logic [INT_BITS-1:0]   r_ip;
    logic [BW-1:0]         r_a, r_b, r_c, r_d;
    // Error terms f*den - (num << FRAC_BITS) of each bound, two's complement.
    logic [EW-1:0]         r_e_ab, r_e_cd;
    logic [DENOM_BITS-1:0] r_rn, r_rd;
    logic [PW-1:0]         r_prod;
    logic [NUM_W-1:0]      r_num;
    logic [DENOM_BITS-1:0] r_den;

    logic [DENOM_BITS-1:0] w_lim;
    logic [BW-1:0]         w_lim_ext;
    logic [BW-1:0]         w_mn, w_md;
    logic [EW-1:0]         w_e_sum;
    logic [EW-1:0]         w_f_ext;
    logic [SW-1:0]         w_num_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_den <= DENOM_BITS'(LIMIT_RESET);
        end else if (i_cfg_wr_en) begin
            r_max_den <= i_cfg_wr_data;
        end
    end

    // A limit of zero behaves as a limit of one.
    assign w_lim     = (r_max_den == '0) ? DENOM_BITS'(1) : r_max_den;
    assign w_lim_ext = {1'b0, w_lim};
    assign w_mn      = r_a + r_c;
    assign w_md      = r_b + r_d;
    // The error term of the mediant is the sum of those of its bounds.
    assign w_e_sum   = r_e_ab + r_e_cd;
    assign w_f_ext   = {{(EW-FRAC_BITS){1'b0}}, i_value_fixed[FRAC_BITS-1:0]};
    assign w_num_sum = {{(SW-PW){1'b0}}, r_prod} + {{(SW-DENOM_BITS){1'b0}}, r_rn};

    assign o_status.in_range = (r_b <= w_lim_ext) && (r_d <= w_lim_ext);
    assign o_status.hit      = (w_e_sum == '0);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_ip   <= i_value_fixed[INT_BITS+FRAC_BITS-1:FRAC_BITS];
            r_a    <= '0;
            r_b    <= BW'(1);
            r_c    <= BW'(1);
            r_d    <= BW'(1);
            r_e_ab <= w_f_ext;
            r_e_cd <= w_f_ext - ONE_F;
        end
        if (i_cmd.advance) begin
            if (!w_e_sum[EW-1]) begin
                r_a    <= w_mn;
                r_b    <= w_md;
                r_e_ab <= w_e_sum;
            end else begin
                r_c    <= w_mn;
                r_d    <= w_md;
                r_e_cd <= w_e_sum;
            end
        end
        if (i_cmd.pick_hit) begin
            priority if (w_md <= w_lim_ext) begin
                r_rn <= w_mn[DENOM_BITS-1:0];
                r_rd <= w_md[DENOM_BITS-1:0];
            end else if (r_d > r_b) begin
                r_rn <= r_c[DENOM_BITS-1:0];
                r_rd <= r_d[DENOM_BITS-1:0];
            end else begin
                r_rn <= r_a[DENOM_BITS-1:0];
                r_rd <= r_b[DENOM_BITS-1:0];
            end
        end
        if (i_cmd.pick_end) begin
            if (r_b > w_lim_ext) begin
                r_rn <= r_c[DENOM_BITS-1:0];
                r_rd <= r_d[DENOM_BITS-1:0];
            end else begin
                r_rn <= r_a[DENOM_BITS-1:0];
                r_rd <= r_b[DENOM_BITS-1:0];
            end
        end
        if (i_cmd.mul) begin
            r_prod <= {{DENOM_BITS{1'b0}}, r_ip} * {{INT_BITS{1'b0}}, r_rd};
        end
        if (i_cmd.load_out) begin
            r_num <= w_num_sum[NUM_W-1:0];
            r_den <= r_rd;
        end
    end

    assign o_numerator   = r_num;
    assign o_denominator = r_den;

endmodule

// ----- rtl/bra_controller.sv -----
// Controller: sequences the mediant search, the multiply and the output hand-off.
module bra_controller (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_stall,
    output logic             o_valid,
    input  logic             i_stall,
    input  bra_pkg::t_status i_status,
    output bra_pkg::t_cmd    o_cmd
);
    import bra_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_STEP = 4'b0010,
        S_MUL  = 4'b0100,
        S_SUM  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_STEP;
                end
            end
            S_STEP: begin
                priority if (!i_status.in_range) begin
                    o_cmd.pick_end = 1'b1;
                    n_state        = S_MUL;
                end else if (i_status.hit) begin
                    o_cmd.pick_hit = 1'b1;
                    n_state        = S_MUL;
                end else begin
                    o_cmd.advance = 1'b1;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                // The output register is refilled only once the old result has gone.
                if (!r_out_valid || !i_stall) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = o_cmd.load_out | (r_out_valid & i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;

endmodule

// ----- rtl/best_rational_approximation.sv -----
// Top level of the best rational approximation block.
// Takes an unsigned fixed-point value and returns the fraction numerator/denominator
// found by a Farey mediant search over its fractional part, with the denominator
// bounded by max_denominator (written through i_cfg_wr_en/i_cfg_wr_data, reset 200,
// zero behaves as one); the integer part is folded into the numerator. One request
// is processed at a time: it is accepted, then the mediant loop handles one mediant
// per cycle with one add and compare of the error terms until the search closes;
// then the integer part times the denominator is formed and the output register
// is filled once any earlier result held there has been taken.
// The output register lets a new request be accepted while a result waits.
`include "best_rational_approximation_defines.svh"

module best_rational_approximation #(
    parameter int FRAC_BITS  = bra_pkg::FRAC_BITS_DEF,
    parameter int INT_BITS   = bra_pkg::INT_BITS_DEF,
    parameter int DENOM_BITS = bra_pkg::DENOM_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [DENOM_BITS-1:0]         i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [INT_BITS+FRAC_BITS-1:0] i_value_fixed,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [bra_pkg::NUM_W-1:0]     o_numerator,
    output logic [DENOM_BITS-1:0]         o_denominator
);
    import bra_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    bra_controller u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .i_status (w_status),
        .o_cmd    (w_cmd)
    );

    bra_datapath #(
        .FRAC_BITS  (FRAC_BITS),
        .INT_BITS   (INT_BITS),
        .DENOM_BITS (DENOM_BITS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_value_fixed (i_value_fixed),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .o_numerator   (o_numerator),
        .o_denominator (o_denominator)
    );

    // A delivered result never has a zero denominator.
    `BRA_ASSERT_SAME(a_den_nonzero, o_valid, o_denominator != '0)
    // An accepted request keeps the block busy in the following cycle.
    `BRA_ASSERT_NEXT(a_busy_after_accept, i_valid && !o_stall, o_stall)
    // The output register is never overwritten while a result is held.
    `BRA_ASSERT_SAME(a_no_overwrite, w_cmd.load_out, !o_valid || !i_stall)

endmodule
